// File: design/bthin_pkg.sv
// Shared constants, types and codes of the binary image thinning block.
package bthin_pkg;

	localparam int unsigned MAX_WIDTH  = 256;
	localparam int unsigned MAX_HEIGHT = 256;
	localparam int unsigned CAPACITY   = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned ADDR_W     = $clog2(CAPACITY);
	localparam int unsigned CFG_W      = 9;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;

	localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
	localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;
	localparam logic [CFG_W-1:0] MIN_DIM  = 9'd3;
	localparam logic [CFG_W-1:0] MAX_W    = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAX_H    = CFG_W'(MAX_HEIGHT);
	localparam logic [CFG_W-1:0] DIM_RST  = 9'd256;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_SUB0,
		PH_SUB1,
		PH_CLEAN
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_COPY,
		ST_SCAN,
		ST_EVAL
	} state_t;

	// Window bits: center, then p2..p9 clockwise from north.
	typedef struct packed {
		logic p9;
		logic p8;
		logic p7;
		logic p6;
		logic p5;
		logic p4;
		logic p3;
		logic p2;
		logic ctr;
	} window_t;

endpackage

// File: design/bthin_in_if.sv
// Input channel: opcode and gray pixel with valid/ready.
interface bthin_in_if;
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [bthin_pkg::PIX_W-1:0]    pixel_in;

	modport source (output valid, output opcode, output pixel_in, input ready);
	modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

// File: design/bthin_out_if.sv
// Output channel: thinned pixel and last flag with valid/ready.
interface bthin_out_if;
	logic                           valid;
	logic                           ready;
	logic [bthin_pkg::PIX_W-1:0]    pixel_out;
	logic                           last_pixel;

	modport source (output valid, output pixel_out, output last_pixel, input ready);
	modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// File: design/bthin_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bthin_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/bthin_eval.sv
// Deletion test on one 3x3 window: thinning subiterations and staircase cleanup.
module bthin_eval (
	input  bthin_pkg::window_t win,
	input  bthin_pkg::phase_t  phase,
	output logic               del
);
	logic [7:0] ring;
	logic [3:0] trans;
	logic [3:0] fg;
	logic       m1;
	logic       m2;
	logic       zs_del;
	logic       st_del;

	assign ring = {win.p9, win.p8, win.p7, win.p6, win.p5, win.p4, win.p3, win.p2};

	always_comb begin
		trans = '0;
		for (int k = 0; k < 8; k++) begin
			trans = trans + 4'(!ring[k] && ring[(k + 1) % 8]);
		end
		fg = 4'($countones(ring));
		if (phase == bthin_pkg::PH_SUB1) begin
			m1 = win.p2 && win.p4 && win.p8;
			m2 = win.p2 && win.p6 && win.p8;
		end else begin
			m1 = win.p2 && win.p4 && win.p6;
			m2 = win.p4 && win.p6 && win.p8;
		end
		zs_del = (trans == 4'd1) && (fg >= 4'd2) && (fg <= 4'd6) && !m1 && !m2;
		// nw=p9 n=p2 ne=p3 e=p4 se=p5 s=p6 sw=p7 w=p8
		st_del = (!win.p3 && ((win.p9 && win.p8 && win.p6) || (win.p5 && win.p6 && win.p8)))
			|| (!win.p9 && ((win.p2 && win.p4 && win.p6) || (win.p4 && win.p6 && win.p7)));
		del = win.ctr && ((phase == bthin_pkg::PH_CLEAN) ? st_del : zs_del);
	end
endmodule

// File: design/binary_image_thinning.sv
// Top level of the binary image thinning block.
// Load beats (opcode 0) write one pixel each into the image RAM in raster order, one per
// cycle; a pixel counts as foreground only when it equals 255. The load that completes a
// width x height image starts thinning and the input stays not ready until it ends. Each
// thinning subiteration first copies the image into a snapshot RAM, then walks every
// interior pixel, reading its 3x3 window from the snapshot one bit per cycle and deciding
// deletion. A pass is two subiterations; passes repeat until one deletes nothing, then
// one staircase cleanup sweep of the same form follows. The total run time depends on
// the image. Fetch beats (opcode 1) return the pixels in raster order as 0 or 255, with
// last_pixel set on the final one; after each fetch the input stays not ready until its
// beat is registered for output. Border pixels are never altered. Width and height are
// clamped to 3..256 and must be written only while the block is idle.
module binary_image_thinning (
	input  logic                              clk,
	input  logic                              arst_n,
	bthin_in_if.sink                          din,
	bthin_out_if.source                       dout,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bthin_pkg::PADDR_W-1:0]     paddr,
	input  logic [bthin_pkg::PDATA_W-1:0]     pwdata,
	output logic [bthin_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	localparam int unsigned AW = bthin_pkg::ADDR_W;
	localparam int unsigned CW = bthin_pkg::CNT_W;
	localparam int unsigned DW = bthin_pkg::CFG_W;

	// Configuration registers.
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == bthin_pkg::REG_HEIGHT) ? bthin_pkg::PDATA_W'(height_q)
		: bthin_pkg::PDATA_W'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bthin_pkg::DIM_RST;
			height_q <= bthin_pkg::DIM_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == bthin_pkg::REG_HEIGHT) begin
				height_q <= pwdata[DW-1:0];
			end else begin
				width_q <= pwdata[DW-1:0];
			end
		end
	end

	// Clamped size and pixel count.
	logic [DW-1:0] w_cl;
	logic [DW-1:0] h_cl;
	logic [CW-1:0] n_pix;

	always_comb begin
		w_cl = (width_q < bthin_pkg::MIN_DIM) ? bthin_pkg::MIN_DIM
			: (width_q > bthin_pkg::MAX_W) ? bthin_pkg::MAX_W : width_q;
		h_cl = (height_q < bthin_pkg::MIN_DIM) ? bthin_pkg::MIN_DIM
			: (height_q > bthin_pkg::MAX_H) ? bthin_pkg::MAX_H : height_q;
		n_pix = CW'(w_cl) * CW'(h_cl);
	end

	// Control and datapath state.
	bthin_pkg::state_t state_q, state_d;
	bthin_pkg::phase_t phase_q;
	logic [CW-1:0] load_cnt_q;
	logic [CW-1:0] fetch_cnt_q;
	logic          fetch_ok_q;
	logic          fetch_last_q;
	logic          deleted_q;
	logic [DW-1:0] w_run_q;
	logic [DW-1:0] h_run_q;
	logic [CW-1:0] n_run_q;
	logic [CW-1:0] copy_k_q;
	logic          copy_v_s1;
	logic [AW-1:0] copy_a_s1;
	logic [AW-1:0] idx_q;
	logic [DW-1:0] row_q;
	logic [DW-1:0] col_q;
	logic [3:0]    step_q;
	bthin_pkg::window_t win_q;
	logic          out_valid_q;
	logic [bthin_pkg::PIX_W-1:0] out_pix_q;
	logic          out_last_q;

	// RAM ports.
	logic          img_we;
	logic [AW-1:0] img_waddr;
	logic          img_wdata;
	logic          img_re;
	logic [AW-1:0] img_raddr;
	logic          img_rdata;
	logic          snap_re;
	logic [AW-1:0] snap_raddr;
	logic          snap_rdata;

	bthin_ram #(.WIDTH(1), .DEPTH(bthin_pkg::CAPACITY)) u_img_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (img_wdata),
		.re    (img_re),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	bthin_ram #(.WIDTH(1), .DEPTH(bthin_pkg::CAPACITY)) u_snap_ram (
		.clk   (clk),
		.we    (copy_v_s1),
		.waddr (copy_a_s1),
		.wdata (img_rdata),
		.re    (snap_re),
		.raddr (snap_raddr),
		.rdata (snap_rdata)
	);

	logic del;

	bthin_eval u_eval (
		.win   (win_q),
		.phase (phase_q),
		.del   (del)
	);

	logic          acc;
	logic          is_load;
	logic [CW-1:0] load_next;
	logic          load_done;
	logic          out_free;
	logic          scan_last;
	logic [AW-1:0] wv;

	assign din.ready       = (state_q == bthin_pkg::ST_IDLE);
	assign acc             = din.valid && din.ready;
	assign is_load         = (din.opcode == bthin_pkg::OP_LOAD);
	assign load_next       = load_cnt_q + CW'(1);
	assign load_done       = (load_next >= n_pix);
	assign out_free        = !out_valid_q || dout.ready;
	assign scan_last       = (col_q == w_run_q - DW'(2)) && (row_q == h_run_q - DW'(2));
	assign wv              = AW'(w_run_q);
	assign dout.valid      = out_valid_q;
	assign dout.pixel_out  = out_pix_q;
	assign dout.last_pixel = out_last_q;

	// Window read address for the current step.
	always_comb begin
		case (step_q)
			4'd0:    snap_raddr = idx_q;
			4'd1:    snap_raddr = idx_q - wv;
			4'd2:    snap_raddr = idx_q - wv + AW'(1);
			4'd3:    snap_raddr = idx_q + AW'(1);
			4'd4:    snap_raddr = idx_q + wv + AW'(1);
			4'd5:    snap_raddr = idx_q + wv;
			4'd6:    snap_raddr = idx_q + wv - AW'(1);
			4'd7:    snap_raddr = idx_q - AW'(1);
			4'd8:    snap_raddr = idx_q - wv - AW'(1);
			default: snap_raddr = idx_q;
		endcase
	end

	// Next state and RAM controls.
	always_comb begin
		state_d   = state_q;
		img_we    = 1'b0;
		img_waddr = load_cnt_q[AW-1:0];
		img_wdata = (din.pixel_in == bthin_pkg::FG_VALUE);
		img_re    = 1'b0;
		img_raddr = fetch_cnt_q[AW-1:0];
		snap_re   = 1'b0;
		case (state_q)
			bthin_pkg::ST_IDLE: begin
				if (acc && is_load) begin
					img_we = (load_cnt_q < n_pix);
					if (load_done) begin
						state_d = bthin_pkg::ST_COPY;
					end
				end else if (acc) begin
					img_re  = 1'b1;
					state_d = bthin_pkg::ST_FETCH;
				end
			end
			bthin_pkg::ST_FETCH: begin
				if (out_free) begin
					state_d = bthin_pkg::ST_IDLE;
				end
			end
			bthin_pkg::ST_COPY: begin
				img_raddr = copy_k_q[AW-1:0];
				img_re    = (copy_k_q < n_run_q);
				if (copy_k_q == n_run_q) begin
					state_d = bthin_pkg::ST_SCAN;
				end
			end
			bthin_pkg::ST_SCAN: begin
				snap_re = (step_q < 4'd9);
				if (step_q == 4'd9) begin
					state_d = bthin_pkg::ST_EVAL;
				end
			end
			bthin_pkg::ST_EVAL: begin
				img_we    = del;
				img_waddr = idx_q;
				img_wdata = 1'b0;
				if (!scan_last) begin
					state_d = bthin_pkg::ST_SCAN;
				end else if (phase_q == bthin_pkg::PH_CLEAN) begin
					state_d = bthin_pkg::ST_IDLE;
				end else begin
					state_d = bthin_pkg::ST_COPY;
				end
			end
			default: state_d = bthin_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bthin_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: load and fetch counters, phase, deletion flag, copy and step counters, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= bthin_pkg::PH_SUB0;
			load_cnt_q  <= '0;
			fetch_cnt_q <= '0;
			deleted_q   <= 1'b0;
			copy_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			copy_k_q    <= '0;
			step_q      <= '0;
		end else begin
			copy_v_s1 <= (state_q == bthin_pkg::ST_COPY) && (copy_k_q < n_run_q);
			// Raise the output beat once the fetched bit is back; drop it when taken.
			if (state_q == bthin_pkg::ST_FETCH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bthin_pkg::ST_IDLE: begin
					if (acc && is_load) begin
						if (load_done) begin
							load_cnt_q  <= '0;
							fetch_cnt_q <= '0;
							phase_q     <= bthin_pkg::PH_SUB0;
							deleted_q   <= 1'b0;
							copy_k_q    <= '0;
						end else begin
							load_cnt_q <= load_next;
						end
					end else if (acc) begin
						// Advance the fetch pointer; wrap after the last pixel.
						if (fetch_cnt_q + CW'(1) >= n_pix) begin
							fetch_cnt_q <= '0;
						end else begin
							fetch_cnt_q <= fetch_cnt_q + CW'(1);
						end
					end
				end
				bthin_pkg::ST_COPY: begin
					if (copy_k_q < n_run_q) begin
						copy_k_q <= copy_k_q + CW'(1);
					end
					step_q <= '0;
				end
				bthin_pkg::ST_SCAN: begin
					step_q <= step_q + 4'd1;
				end
				bthin_pkg::ST_EVAL: begin
					step_q   <= '0;
					copy_k_q <= '0;
					// Clear the flag at the end of a pass, else note any deletion.
					if (scan_last && phase_q == bthin_pkg::PH_SUB1) begin
						deleted_q <= 1'b0;
					end else if (del) begin
						deleted_q <= 1'b1;
					end
					if (scan_last) begin
						case (phase_q)
							bthin_pkg::PH_SUB0: phase_q <= bthin_pkg::PH_SUB1;
							bthin_pkg::PH_SUB1: begin
								// Repeat the pass while anything was deleted.
								if (deleted_q || del) begin
									phase_q <= bthin_pkg::PH_SUB0;
								end else begin
									phase_q <= bthin_pkg::PH_CLEAN;
								end
							end
							default: phase_q <= bthin_pkg::PH_SUB0;
						endcase
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

	// Payload registers: copy write address, sizes, fetch flags, walk position, window, output beat.
	always_ff @(posedge clk) begin
		copy_a_s1 <= copy_k_q[AW-1:0];
		if (state_q == bthin_pkg::ST_IDLE && acc && is_load && load_done) begin
			w_run_q <= w_cl;
			h_run_q <= h_cl;
			n_run_q <= n_pix;
		end
		if (state_q == bthin_pkg::ST_IDLE && acc && !is_load) begin
			fetch_ok_q   <= (fetch_cnt_q < n_pix);
			fetch_last_q <= (fetch_cnt_q + CW'(1) >= n_pix);
		end
		if (state_q == bthin_pkg::ST_FETCH && out_free) begin
			out_pix_q  <= (fetch_ok_q && img_rdata) ? bthin_pkg::FG_VALUE : bthin_pkg::BG_VALUE;
			out_last_q <= fetch_last_q;
		end
		if (state_q == bthin_pkg::ST_COPY) begin
			idx_q <= wv + AW'(1);
			row_q <= DW'(1);
			col_q <= DW'(1);
		end
		if (state_q == bthin_pkg::ST_SCAN) begin
			case (step_q)
				4'd1:    win_q.ctr <= snap_rdata;
				4'd2:    win_q.p2  <= snap_rdata;
				4'd3:    win_q.p3  <= snap_rdata;
				4'd4:    win_q.p4  <= snap_rdata;
				4'd5:    win_q.p5  <= snap_rdata;
				4'd6:    win_q.p6  <= snap_rdata;
				4'd7:    win_q.p7  <= snap_rdata;
				4'd8:    win_q.p8  <= snap_rdata;
				4'd9:    win_q.p9  <= snap_rdata;
				default: win_q     <= win_q;
			endcase
		end
		if (state_q == bthin_pkg::ST_EVAL && !scan_last) begin
			// Step along the row; skip the border pixel at its end and the one at the start of the next row.
			if (col_q == w_run_q - DW'(2)) begin
				col_q <= DW'(1);
				row_q <= row_q + DW'(1);
				idx_q <= idx_q + AW'(3);
			end else begin
				col_q <= col_q + DW'(1);
				idx_q <= idx_q + AW'(1);
			end
		end
	end
endmodule

// File: verif/tb_binary_image_thinning.sv
// Testbench for the binary image thinning block: predicted thinned pixels vs fetched beats.
module tb_binary_image_thinning;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 8000000;
	localparam int unsigned ITEM_GOAL   = 1000;
	localparam int unsigned QUIET_AFTER = 850;
	localparam int unsigned SETTLE_CYC  = 8;
	localparam int unsigned HEAD_FETCH  = 64;
	localparam logic [bthin_pkg::CNT_W-1:0] CNT_MASK = '1;

	typedef struct {
		logic [bthin_pkg::PIX_W-1:0] pixel;
		logic                        last;
	} out_beat_t;

	// Scoreboard: keeps its own copy of the image, counters and size registers,
	// predicts each fetch beat and checks the block's answers in order.
	class thin_scoreboard;
		logic [bthin_pkg::CFG_W-1:0] width_reg  = bthin_pkg::DIM_RST;
		logic [bthin_pkg::CFG_W-1:0] height_reg = bthin_pkg::DIM_RST;
		bit               img[bthin_pkg::CAPACITY];
		bit               snap[bthin_pkg::CAPACITY];
		int unsigned      load_cnt;
		int unsigned      fetch_cnt;
		bit               deleted;
		out_beat_t        pending_q[$];
		int unsigned      errors;

		function int unsigned clamp_dim(logic [bthin_pkg::CFG_W-1:0] v, int unsigned mx);
			if (v < bthin_pkg::MIN_DIM) return bthin_pkg::MIN_DIM;
			if (v > mx) return mx;
			return v;
		endfunction

		function int unsigned cols();
			return clamp_dim(width_reg, bthin_pkg::MAX_WIDTH);
		endfunction

		function int unsigned rows();
			return clamp_dim(height_reg, bthin_pkg::MAX_HEIGHT);
		endfunction

		function void write_reg(bthin_pkg::reg_idx_t idx, logic [bthin_pkg::CFG_W-1:0] v);
			if (idx == bthin_pkg::REG_WIDTH) width_reg = v;
			else height_reg = v;
		endfunction

		// One sweep over the interior from a snapshot: phase picks the first or
		// second thinning subiteration, or the staircase cleanup.
		function void sweep(int unsigned w, int unsigned h, bthin_pkg::phase_t ph);
			int unsigned i, a, b;
			bit p2, p3, p4, p5, p6, p7, p8, p9, m1, m2, kill;
			for (int unsigned k = 0; k < w * h; k++) snap[k] = img[k];
			for (int unsigned r = 1; r + 1 < h; r++) begin
				for (int unsigned c = 1; c + 1 < w; c++) begin
					i = r * w + c;
					if (!snap[i]) continue;
					p2 = snap[i - w];     p3 = snap[i - w + 1];
					p4 = snap[i + 1];     p5 = snap[i + w + 1];
					p6 = snap[i + w];     p7 = snap[i + w - 1];
					p8 = snap[i - 1];     p9 = snap[i - w - 1];
					if (ph == bthin_pkg::PH_CLEAN) begin
						kill = (!p3 && ((p9 && p8 && p6) || (p5 && p6 && p8))) ||
						       (!p9 && ((p2 && p4 && p6) || (p4 && p6 && p7)));
						if (kill) img[i] = 1'b0;
					end else begin
						a = (!p2 && p3) + (!p3 && p4) + (!p4 && p5) + (!p5 && p6) +
						    (!p6 && p7) + (!p7 && p8) + (!p8 && p9) + (!p9 && p2);
						b = p2 + p3 + p4 + p5 + p6 + p7 + p8 + p9;
						if (ph == bthin_pkg::PH_SUB1) begin
							m1 = p2 && p4 && p8;
							m2 = p2 && p6 && p8;
						end else begin
							m1 = p2 && p4 && p6;
							m2 = p4 && p6 && p8;
						end
						if (a == 1 && b >= 2 && b <= 6 && !m1 && !m2) begin
							img[i] = 1'b0;
							deleted = 1'b1;
						end
					end
				end
			end
		endfunction

		function void thin_image();
			do begin
				deleted = 1'b0;
				sweep(cols(), rows(), bthin_pkg::PH_SUB0);
				sweep(cols(), rows(), bthin_pkg::PH_SUB1);
			end while (deleted);
			sweep(cols(), rows(), bthin_pkg::PH_CLEAN);
		endfunction

		// Note an accepted input beat; a fetch queues its expected answer.
		function void note_input(bthin_pkg::op_t op, logic [bthin_pkg::PIX_W-1:0] px);
			int unsigned n;
			out_beat_t e;
			n = cols() * rows();
			if (op == bthin_pkg::OP_LOAD) begin
				if (load_cnt < n) img[load_cnt] = (px == bthin_pkg::FG_VALUE);
				load_cnt = (load_cnt + 1) & CNT_MASK;
				if (load_cnt >= n) begin
					thin_image();
					load_cnt  = 0;
					fetch_cnt = 0;
				end
			end else begin
				e.pixel = (fetch_cnt < n && img[fetch_cnt]) ? bthin_pkg::FG_VALUE
					: bthin_pkg::BG_VALUE;
				if (fetch_cnt + 1 >= n) begin
					e.last    = 1'b1;
					fetch_cnt = 0;
				end else begin
					e.last    = 1'b0;
					fetch_cnt = (fetch_cnt + 1) & CNT_MASK;
				end
				pending_q.push_back(e);
			end
		endfunction

		function void check_output(logic [bthin_pkg::PIX_W-1:0] px, logic last);
			out_beat_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected output beat pixel_out=%0d last_pixel=%0b",
				         $time, px, last);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (px !== e.pixel) begin
				$display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel, px);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_pixel expected %0b actual %0b", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [bthin_pkg::PADDR_W-1:0] paddr;
	logic [bthin_pkg::PDATA_W-1:0] pwdata;
	wire  [bthin_pkg::PDATA_W-1:0] prdata;
	wire               pready;

	bthin_in_if  din_if();
	bthin_out_if dout_if();

	binary_image_thinning DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din_if),
		.dout    (dout_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	thin_scoreboard sb = new();
	int unsigned    items_in;
	int unsigned    idle_cycles;
	int unsigned    filled;       // largest pixel count fully loaded so far
	bit             quiet;
	int             rx_stall;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: stall the output in bursts of random length until the quiet tail.
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			dout_if.ready <= 1'b0;
			rx_stall--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			dout_if.ready <= 1'b0;
			rx_stall = $urandom_range(1, 8) - 1;
		end else begin
			dout_if.ready <= 1'b1;
		end
	end

	// Monitor: both channels are sampled at the rising edge; the watchdog counts
	// cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (din_if.valid && din_if.ready || dout_if.valid && dout_if.ready)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (din_if.valid && din_if.ready) begin
				sb.note_input(bthin_pkg::op_t'(din_if.opcode), din_if.pixel_in);
				items_in++;
				if (items_in > QUIET_AFTER) quiet = 1'b1;
			end
			if (dout_if.valid && dout_if.ready)
				sb.check_output(dout_if.pixel_out, dout_if.last_pixel);
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired, no beat for %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Send one beat; sometimes hold valid low for a burst first.
	task automatic send_beat(bthin_pkg::op_t op, logic [bthin_pkg::PIX_W-1:0] px);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			din_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		din_if.valid    <= 1'b1;
		din_if.opcode   <= op;
		din_if.pixel_in <= px;
		do @(posedge clk); while (!din_if.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected beat is back and the block is idle.
	task automatic settle();
		din_if.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		while (!din_if.ready) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic apb_write(bthin_pkg::reg_idx_t idx, logic [bthin_pkg::CFG_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bthin_pkg::PADDR_W'(4 * idx);
		pwdata  <= bthin_pkg::PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_size(logic [bthin_pkg::CFG_W-1:0] w, logic [bthin_pkg::CFG_W-1:0] h);
		settle();
		apb_write(bthin_pkg::REG_WIDTH, w);
		apb_write(bthin_pkg::REG_HEIGHT, h);
	endtask

	function automatic logic [bthin_pkg::PIX_W-1:0] gray(int unsigned fg_pct);
		if ($urandom_range(0, 99) < fg_pct) return bthin_pkg::FG_VALUE;
		return bthin_pkg::PIX_W'($urandom_range(0, 254));
	endfunction

	task automatic load_pixels(int unsigned n, int unsigned fg_pct);
		for (int unsigned k = 0; k < n; k++) send_beat(bthin_pkg::OP_LOAD, gray(fg_pct));
	endtask

	task automatic fetch_pixels(int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			send_beat(bthin_pkg::OP_FETCH, bthin_pkg::PIX_W'($urandom));
	endtask

	initial begin
		int unsigned w, h, n, nb, k, pct, kind, phase_no;
		arst_n           = 1'b0;
		din_if.valid     = 1'b0;
		din_if.opcode    = bthin_pkg::OP_LOAD;
		din_if.pixel_in  = '0;
		dout_if.ready    = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: smallest image, mostly foreground with the gray values 254 and 0 in it,
		// then a mid-image hold until every fetched beat has come back.
		set_size(bthin_pkg::MIN_DIM, bthin_pkg::MIN_DIM);
		send_beat(bthin_pkg::OP_LOAD, bthin_pkg::FG_VALUE);
		send_beat(bthin_pkg::OP_LOAD, 8'd254);
		send_beat(bthin_pkg::OP_LOAD, 8'd0);
		for (k = 0; k < 6; k++) send_beat(bthin_pkg::OP_LOAD, bthin_pkg::FG_VALUE);
		fetch_pixels(4);
		settle();
		fetch_pixels(5);
		filled = 9;
		// Fetch before thinning: a partial load overwrites raw bits that a fetch
		// then reads back next to the thinned ones.
		send_beat(bthin_pkg::OP_LOAD, 8'd127);
		send_beat(bthin_pkg::OP_LOAD, bthin_pkg::FG_VALUE);
		fetch_pixels(3);

		// Random phases of mostly well-formed images, one of them at a size extreme.
		phase_no = 0;
		while (items_in < ITEM_GOAL) begin
			phase_no++;
			kind = $urandom_range(0, 9);
			pct  = $urandom_range(20, 95);
			if (phase_no == 3) begin
				// Out-of-range register values clamp to a 256-wide or a 256-tall image;
				// fetch only its head.
				if ($urandom_range(0, 1) == 0) set_size(9'h1FF, 9'h000);
				else set_size(9'h002, 9'h1FF);
				n = sb.cols() * sb.rows();
				load_pixels(n, pct);
				fetch_pixels(HEAD_FETCH);
				if (n > filled) filled = n;
			end else if (kind == 0 && filled >= 12) begin
				// Fetch past a shrunken image: the first fetch returns 0 with last set.
				w = $urandom_range(4, 8);
				h = $urandom_range(4, 8);
				set_size(bthin_pkg::CFG_W'(w), bthin_pkg::CFG_W'(h));
				n = w * h;
				load_pixels(n, pct);
				k = $urandom_range(10, n - 1);
				fetch_pixels(k);
				set_size(bthin_pkg::MIN_DIM, bthin_pkg::MIN_DIM);
				fetch_pixels(10);
			end else if (kind == 1) begin
				// Load past a shrunken image: the next load is dropped and starts thinning.
				w = $urandom_range(4, 8);
				h = $urandom_range(4, 8);
				set_size(bthin_pkg::CFG_W'(w), bthin_pkg::CFG_W'(h));
				n = w * h;
				nb = $urandom_range(9, 15);
				k = $urandom_range(nb, n - 1);
				load_pixels(k, pct);
				settle();
				set_size(bthin_pkg::MIN_DIM, bthin_pkg::CFG_W'(nb / 3));
				send_beat(bthin_pkg::OP_LOAD, gray(pct));
				fetch_pixels(3 * (nb / 3));
			end else begin
				w = $urandom_range(3, 12);
				h = $urandom_range(3, 12);
				set_size(bthin_pkg::CFG_W'(w), bthin_pkg::CFG_W'(h));
				n = w * h;
				// Noise: a few random beats before the image, only where every read
				// lands on pixels that were loaded before.
				if (n <= filled && $urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 10))
						send_beat(bthin_pkg::op_t'($urandom_range(0, 1)),
						          bthin_pkg::PIX_W'($urandom));
				end
				load_pixels(n, pct);
				fetch_pixels(n);
				if (n > filled) filled = n;
			end
		end

		settle();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0t: %0d mismatches, %0d beats still expected", $time, sb.errors,
			         sb.pending_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
